// ----- sv/sacmc_pkg.sv -----
// Package: shared types and constants for the cache miss classifier.
`default_nettype none
package sacmc_pkg;
    localparam int SETS_DEF     = 64;
    localparam int WAYS_DEF     = 4;
    localparam int TAG_BITS_DEF = 20;
    localparam int SET_W        = 6;
    localparam int TAG_W        = 20;
    localparam int CNT_W        = 32;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    typedef enum logic [1:0] {
        POL_RANDOM = 2'd0,
        POL_LRU    = 2'd1,
        POL_FIFO   = 2'd2,
        POL_FIFO3  = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        OUT_HIT        = 2'd0,
        OUT_COMPULSORY = 2'd1,
        OUT_CONFLICT   = 2'd2,
        OUT_CAPACITY   = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_CLEAR
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic update;
        logic clear;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done;
    } ctrl_stat_t;
endpackage
`default_nettype wire

// ----- sv/sacmc_ctrl.sv -----
// Controller: sequences lookup read, update and the post-reset set-memory clear.
`default_nettype none
module sacmc_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire sacmc_pkg::ctrl_stat_t stat,
    output sacmc_pkg::ctrl_cmd_t     cmd,
    output logic                     busy
);
    import sacmc_pkg::*;

    state_t state_reg, state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (stat.clear_done) state_next = ST_IDLE;
            ST_IDLE:   if (start) state_next = ST_READ;
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_CLEAR:  cmd.clear = 1'b1;
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ST_READ:   ;
            ST_UPDATE: cmd.update = 1'b1;
            default:   ;
        endcase
    end
endmodule
`default_nettype wire

// ----- sv/sacmc_dp.sv -----
// Datapath: set memory, hit and victim selection, counters and LFSR.
`default_nettype none
module sacmc_dp
#(
    parameter int SETS     = sacmc_pkg::SETS_DEF,
    parameter int WAYS     = sacmc_pkg::WAYS_DEF,
    parameter int TAG_BITS = sacmc_pkg::TAG_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire sacmc_pkg::ctrl_cmd_t     cmd,
    output sacmc_pkg::ctrl_stat_t         stat,
    input  wire logic                     cfg_we,
    input  wire logic [1:0]               cfg_data,
    input  wire logic [sacmc_pkg::SET_W-1:0] set_index,
    input  wire logic [sacmc_pkg::TAG_W-1:0] tag,
    output logic                          done,
    output logic [1:0]                    outcome,
    output logic [sacmc_pkg::CNT_W-1:0]   compulsory_count,
    output logic [sacmc_pkg::CNT_W-1:0]   conflict_count,
    output logic [sacmc_pkg::CNT_W-1:0]   capacity_count
);
    import sacmc_pkg::*;

    localparam int SI_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TOT   = SETS * WAYS;
    localparam int VT_W  = $clog2(TOT + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // One row per set: valid, rank and tag of every way
    typedef struct packed {
        logic [WAYS-1:0]              vld;
        logic [WAYS-1:0][WY_W-1:0]    rank;
        logic [WAYS-1:0][TAG_BITS-1:0] tags;
    } row_t;

    row_t                 mem [SETS];
    row_t                 rd_reg;
    logic [SI_W-1:0]      set_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [SI_W-1:0]      clr_reg;
    logic [1:0]           pol_reg;
    logic [VT_W-1:0]      vt_reg;
    logic [15:0]          lfsr_reg;
    logic [CNT_W-1:0]     comp_reg, conf_reg, cap_reg;
    logic                 done_reg;
    logic [1:0]           out_reg;

    logic [SI_W-1:0]      set_in;
    row_t                 row_init;
    row_t                 row_new;
    logic                 hit;
    logic                 has_inv;
    logic [WY_W-1:0]      hit_way, inv_way, old_way, rnd_way, tgt_way;
    logic                 do_rank;
    logic                 do_tag;
    logic [1:0]           oc_next;

    // Reduce set index modulo SETS
    always_comb
    begin
        set_in = SI_W'({26'd0, set_index} % SETS);
    end

    // Build the reset row: invalid, rank equals way number
    always_comb
    begin
        row_init = '0;
        for (int w = 0; w < WAYS; w++)
            row_init.rank[w] = WY_W'(w);
    end

    // Select hit, oldest invalid and oldest way
    always_comb
    begin
        hit     = 1'b0;
        has_inv = 1'b0;
        hit_way = '0;
        inv_way = '0;
        old_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (rd_reg.vld[w])
            begin
                if (!hit && rd_reg.tags[w] == tag_reg)
                begin
                    hit     = 1'b1;
                    hit_way = WY_W'(w);
                end
            end
            else if (!has_inv || rd_reg.rank[w] < rd_reg.rank[inv_way])
            begin
                has_inv = 1'b1;
                inv_way = WY_W'(w);
            end
            if (rd_reg.rank[w] < rd_reg.rank[old_way])
                old_way = WY_W'(w);
        end
        rnd_way = WY_W'(lfsr_reg % WAYS);
    end

    // Compute updated row and outcome
    always_comb
    begin
        row_new = rd_reg;
        tgt_way = old_way;
        do_rank = 1'b0;
        do_tag  = 1'b0;
        oc_next = OUT_HIT;
        if (hit)
        begin
            tgt_way = hit_way;
            do_rank = (pol_reg == POL_LRU);
        end
        else if (has_inv)
        begin
            tgt_way = inv_way;
            do_rank = 1'b1;
            do_tag  = 1'b1;
            oc_next = OUT_COMPULSORY;
        end
        else
        begin
            do_tag = 1'b1;
            if (pol_reg == POL_RANDOM)
                tgt_way = rnd_way;
            else
                do_rank = 1'b1;
            oc_next = (vt_reg >= VT_W'(TOT)) ? OUT_CAPACITY : OUT_CONFLICT;
        end
        if (do_tag)
        begin
            row_new.vld[tgt_way]  = 1'b1;
            row_new.tags[tgt_way] = tag_reg;
        end
        if (do_rank)
        begin
            for (int w = 0; w < WAYS; w++)
                if (rd_reg.rank[w] > rd_reg.rank[tgt_way])
                    row_new.rank[w] = rd_reg.rank[w] - 1'b1;
            row_new.rank[tgt_way] = WY_W'(WAYS - 1);
        end
    end

    // Memory: clear sweep, read on capture, write on update
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            mem[clr_reg] <= row_init;
        else if (cmd.update)
            mem[set_reg] <= row_new;
        if (cmd.capture)
            rd_reg <= mem[set_in];
    end

    // Hold the access
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            set_reg <= set_in;
            tag_reg <= tag[TAG_BITS-1:0];
        end
    end

    // Control state, counters and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            pol_reg  <= POL_LRU;
            vt_reg   <= '0;
            lfsr_reg <= 16'd1;
            comp_reg <= '0;
            conf_reg <= '0;
            cap_reg  <= '0;
            done_reg <= 1'b0;
            out_reg  <= OUT_HIT;
        end
        else
        begin
            done_reg <= cmd.update;
            if (cmd.clear)
                clr_reg <= clr_reg + 1'b1;
            if (cfg_we)
                pol_reg <= cfg_data;
            if (cmd.update)
            begin
                out_reg  <= oc_next;
                lfsr_reg <= (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_MASK : 16'd0);
                unique case (oc_next)
                    OUT_COMPULSORY:
                    begin
                        if (comp_reg != CNT_MAX) comp_reg <= comp_reg + 1'b1;
                        if (vt_reg < VT_W'(TOT)) vt_reg <= vt_reg + 1'b1;
                    end
                    OUT_CONFLICT: if (conf_reg != CNT_MAX) conf_reg <= conf_reg + 1'b1;
                    OUT_CAPACITY: if (cap_reg != CNT_MAX) cap_reg <= cap_reg + 1'b1;
                    default: ;
                endcase
            end
        end
    end

    assign stat.clear_done = (clr_reg == SI_W'(SETS - 1));
    assign done             = done_reg;
    assign outcome          = out_reg;
    assign compulsory_count = comp_reg;
    assign conflict_count   = conf_reg;
    assign capacity_count   = cap_reg;
endmodule
`default_nettype wire

// ----- sv/set_assoc_cache_miss_classifier.sv -----
// Top level: set-associative cache miss classifier.
//
//  channel  | handshake          | payload
//  access   | start / busy       | set_index, tag
//  result   | done (one cycle)   | outcome, compulsory_count, conflict_count, capacity_count
//  config   | policy_we          | policy_data
//
// An access runs from start to done through capture and row read, select,
// then row write-back; a new access is taken once busy drops.
// After reset busy stays high while the set memory is cleared.
// The receiver cannot stall; done marks a beat valid for one cycle.
`default_nettype none
module set_assoc_cache_miss_classifier
#(
    parameter int SETS     = sacmc_pkg::SETS_DEF,
    parameter int WAYS     = sacmc_pkg::WAYS_DEF,
    parameter int TAG_BITS = sacmc_pkg::TAG_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [sacmc_pkg::SET_W-1:0] set_index,
    input  wire logic [sacmc_pkg::TAG_W-1:0] tag,
    input  wire logic                        policy_we,
    input  wire logic [1:0]                  policy_data,
    output logic                             done,
    output logic [1:0]                       outcome,
    output logic [sacmc_pkg::CNT_W-1:0]      compulsory_count,
    output logic [sacmc_pkg::CNT_W-1:0]      conflict_count,
    output logic [sacmc_pkg::CNT_W-1:0]      capacity_count
);
    import sacmc_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    sacmc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sacmc_dp #(.SETS(SETS), .WAYS(WAYS), .TAG_BITS(TAG_BITS)) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (policy_we),
        .cfg_data         (policy_data),
        .set_index        (set_index),
        .tag              (tag),
        .done             (done),
        .outcome          (outcome),
        .compulsory_count (compulsory_count),
        .conflict_count   (conflict_count),
        .capacity_count   (capacity_count)
    );
endmodule
`default_nettype wire

// ----- sv/sacmc_checker.sv -----
// Checker: port-level properties of the cache miss classifier, with bind.
`default_nettype none
module sacmc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  outcome,
    input wire logic [31:0] compulsory_count,
    input wire logic [31:0] conflict_count,
    input wire logic [31:0] capacity_count
);
    // An accepted access raises busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");

    // A result follows an accepted access after the read and update states
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done) else $error("result missing");

    // Counters move only with a result
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(compulsory_count) && $stable(conflict_count)
                  && $stable(capacity_count)) else $error("counter moved");

    // A hit leaves every counter unchanged
    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && outcome == 2'd0) |-> $stable(compulsory_count)
            && $stable(conflict_count) && $stable(capacity_count))
        else $error("hit changed counters");
endmodule

bind set_assoc_cache_miss_classifier sacmc_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .outcome(outcome), .compulsory_count(compulsory_count),
    .conflict_count(conflict_count), .capacity_count(capacity_count)
);
`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for the set-associative cache miss classifier: predictor, scoreboard, stimulus.
`default_nettype none

class miss_scoreboard;
    logic [19:0] tag_mem [256];
    bit          valid_mem [256];
    logic [1:0]  rank_mem [256];
    int unsigned valid_cnt;
    logic [15:0] lfsr;
    logic [31:0] comp_tot, confl_tot, cap_tot;
    sacmc_pkg::policy_t policy;
    // Ring of expected result beats
    sacmc_pkg::outcome_t want_outcome [16];
    logic [31:0] want_comp [16], want_confl [16], want_cap [16];
    int want_head;
    int want_cnt;
    int errors;

    function new();
        errors = 0;
        for (int i = 0; i < 256; i++)
        begin
            valid_mem[i] = 1'b0;
            rank_mem[i] = 2'(i % 4);
            tag_mem[i] = '0;
        end
        valid_cnt = 0;
        lfsr = 16'd1;
        comp_tot = '0;
        confl_tot = '0;
        cap_tot = '0;
        policy = sacmc_pkg::POL_LRU;
        want_head = 0;
        want_cnt = 0;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    function void promote(int base, int way);
        logic [1:0] cur;
        cur = rank_mem[base + way];
        for (int w = 0; w < 4; w++)
            if (rank_mem[base + w] > cur)
                rank_mem[base + w] = rank_mem[base + w] - 1;
        rank_mem[base + way] = 2'd3;
    endfunction

    // Note an accepted access and queue its classification.
    function void note_access(logic [5:0] set_idx, logic [19:0] tg);
        int base, hit_w, inv_w, old_w, v, slot;
        sacmc_pkg::outcome_t oc;
        base = int'(set_idx) * 4;
        hit_w = -1;
        inv_w = -1;
        old_w = 0;
        for (int w = 0; w < 4; w++)
        begin
            if (valid_mem[base + w])
            begin
                if (hit_w < 0 && tag_mem[base + w] == tg)
                    hit_w = w;
            end
            else if (inv_w < 0 || rank_mem[base + w] < rank_mem[base + inv_w])
                inv_w = w;
            if (rank_mem[base + w] < rank_mem[base + old_w])
                old_w = w;
        end
        if (hit_w >= 0)
        begin
            if (policy == sacmc_pkg::POL_LRU)
                promote(base, hit_w);
            oc = sacmc_pkg::OUT_HIT;
        end
        else if (inv_w >= 0)
        begin
            valid_mem[base + inv_w] = 1'b1;
            tag_mem[base + inv_w] = tg;
            if (valid_cnt < 256)
                valid_cnt++;
            promote(base, inv_w);
            comp_tot = bump(comp_tot);
            oc = sacmc_pkg::OUT_COMPULSORY;
        end
        else
        begin
            if (policy == sacmc_pkg::POL_RANDOM)
            begin
                v = int'(lfsr[1:0]);
                tag_mem[base + v] = tg;
            end
            else
            begin
                tag_mem[base + old_w] = tg;
                promote(base, old_w);
            end
            if (valid_cnt >= 256)
            begin
                cap_tot = bump(cap_tot);
                oc = sacmc_pkg::OUT_CAPACITY;
            end
            else
            begin
                confl_tot = bump(confl_tot);
                oc = sacmc_pkg::OUT_CONFLICT;
            end
        end
        lfsr = lfsr[0] ? ((lfsr >> 1) ^ sacmc_pkg::LFSR_MASK) : (lfsr >> 1);
        slot = (want_head + want_cnt) % 16;
        want_outcome[slot] = oc;
        want_comp[slot] = comp_tot;
        want_confl[slot] = confl_tot;
        want_cap[slot] = cap_tot;
        want_cnt++;
    endfunction

    // Compare one result beat against the oldest expectation.
    function void check_result(logic [1:0] oc, logic [31:0] cp, logic [31:0] cf,
                               logic [31:0] ca);
        if (want_cnt == 0)
        begin
            $error("unexpected result beat: outcome %0d", oc);
            errors++;
            return;
        end
        if (oc !== want_outcome[want_head])
        begin
            $error("outcome: expected %0d, got %0d", want_outcome[want_head], oc);
            errors++;
        end
        if (cp !== want_comp[want_head])
        begin
            $error("compulsory_count: expected %0d, got %0d", want_comp[want_head], cp);
            errors++;
        end
        if (cf !== want_confl[want_head])
        begin
            $error("conflict_count: expected %0d, got %0d", want_confl[want_head], cf);
            errors++;
        end
        if (ca !== want_cap[want_head])
        begin
            $error("capacity_count: expected %0d, got %0d", want_cap[want_head], ca);
            errors++;
        end
        want_head = (want_head + 1) % 16;
        want_cnt--;
    endfunction

    function int pending();
        return want_cnt;
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sacmc_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [5:0]  set_index;
    logic [19:0] tag;
    logic        policy_we;
    logic [1:0]  policy_data;
    logic        done;
    logic [1:0]  outcome;
    logic [31:0] compulsory_count, conflict_count, capacity_count;

    miss_scoreboard sb;
    int idle_cycles;
    // Tags of recent accesses, reused to make hits likely.
    logic [19:0] recent_tags [12];
    int recent_cnt;
    int recent_wr;

    set_assoc_cache_miss_classifier dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .set_index(set_index),
        .tag(tag),
        .policy_we(policy_we),
        .policy_data(policy_data),
        .done(done),
        .outcome(outcome),
        .compulsory_count(compulsory_count),
        .conflict_count(conflict_count),
        .capacity_count(capacity_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Check result beats and note accepted accesses at each edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(outcome, compulsory_count, conflict_count, capacity_count);
            if (start && !busy)
                sb.note_access(set_index, tag);
        end
    end

    // Watchdog: end the run when no access is accepted and no result arrives for too long.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Hold the access until accepted, then drop start and step past the accept edge.
    task automatic send_access(logic [5:0] s, logic [19:0] t);
        start <= 1'b1;
        set_index <= s;
        tag <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic sender_gap();
        int n;
        if ($urandom_range(0, 2) == 0)
            return;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_policy(policy_t p);
        drain();
        policy_we <= 1'b1;
        policy_data <= p;
        @(posedge clk);
        policy_we <= 1'b0;
        sb.policy = p;
    endtask

    // Random access: half reuse recent tags, most go to the four hot sets 0 to 3.
    task automatic random_access();
        logic [5:0] s;
        logic [19:0] t;
        int pick;
        pick = $urandom_range(0, 9);
        s = (pick < 6) ? 6'($urandom_range(0, 3)) : 6'($urandom);
        if (pick < 5 && recent_cnt > 0)
            t = recent_tags[$urandom_range(0, recent_cnt - 1)];
        else
            t = (pick == 9) ? 20'($urandom) : 20'($urandom_range(0, 7));
        recent_tags[recent_wr] = t;
        recent_wr = (recent_wr + 1) % 12;
        if (recent_cnt < 12)
            recent_cnt++;
        send_access(s, t);
        sender_gap();
    endtask

    initial
    begin
        policy_t plist [4];
        sb = new();
        idle_cycles = 0;
        recent_cnt = 0;
        recent_wr = 0;
        rst_n = 1'b0;
        start = 1'b0;
        set_index = '0;
        tag = '0;
        policy_we = 1'b0;
        policy_data = POL_LRU;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, fill one set, hit, conflict evictions, then FIFO and random policies.
        send_access(6'd0, 20'd0);
        send_access(6'd63, 20'hFFFFF);
        send_access(6'd0, 20'd0);
        send_access(6'd63, 20'hFFFFF);
        for (int i = 1; i < 6; i++)
            send_access(6'd0, 20'(i));
        send_access(6'd0, 20'd3);
        send_access(6'd0, 20'hAAAAA);
        send_access(6'd1, 20'h55555);
        set_policy(POL_FIFO);
        for (int i = 0; i < 6; i++)
            send_access(6'd2, 20'(i & 4));
        send_access(6'd2, 20'd7);
        set_policy(POL_RANDOM);
        for (int i = 0; i < 6; i++)
            send_access(6'd3, 20'(i + 16));

        // Fill the whole cache so capacity misses occur.
        set_policy(POL_FIFO3);
        for (int s = 0; s < 64; s++)
            for (int w = 0; w < 4; w++)
                send_access(6'(s), 20'(1000 + w));
        send_access(6'd5, 20'hFFFFE);

        // Random phases under each policy.
        plist[0] = POL_RANDOM;
        plist[1] = POL_LRU;
        plist[2] = POL_FIFO;
        plist[3] = POL_FIFO3;
        for (int ph = 0; ph < 8; ph++)
        begin
            set_policy(plist[ph % 4]);
            repeat (50)
                random_access();
            // Hold off until every result is in.
            drain();
            repeat (15)
                random_access();
        end
        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

`default_nettype wire
